// ===== hw/rtl/pcs_pkg.sv =====
package pcs_pkg;

    localparam int COORD_W         = 48;
    localparam int FRAC_BITS       = 16;
    localparam int CLIP_BOUND_LOG2 = 22;
    localparam int MAT_FRAC        = 16;
    localparam int COEF_W          = 32;
    localparam int PASS_LIMIT      = 8;
    localparam int PASS_W          = $clog2(PASS_LIMIT + 1);
    localparam int MAG_W           = COORD_W + 1;
    localparam int PROD_W          = 2 * MAG_W;
    localparam int ACC_W           = COORD_W + COEF_W + 2;
    localparam int CNT_W           = $clog2(PROD_W + 1);
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = COORD_W;
    localparam int REC_DEPTH       = 3;
    localparam int REC_IDX_W       = $clog2(REC_DEPTH);
    localparam int REC_CNT_W       = $clog2(REC_DEPTH + 1);

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]  t_coef;
    typedef logic [MAG_W-1:0]          t_mag;

    localparam t_coord CMAX   = {1'b0, {(COORD_W-1){1'b1}}};
    localparam t_coord CMIN   = {1'b1, {(COORD_W-1){1'b0}}};
    localparam t_coord BOUND  = t_coord'(1) <<< (CLIP_BOUND_LOG2 + FRAC_BITS);
    localparam t_coord NBOUND = -BOUND;
    localparam logic [FRAC_BITS-1:0] FRAC_HALF = {1'b1, {(FRAC_BITS-1){1'b0}}};

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_XX = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_YX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_YY = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SNAP_MODE = 3'd6;

    localparam logic [1:0] SNAP_NONE  = 2'd0;
    localparam logic [1:0] SNAP_FLOOR = 2'd1;
    localparam logic [1:0] SNAP_ROUND = 2'd2;

    localparam logic [3:0] OC_LEFT   = 4'd1;
    localparam logic [3:0] OC_RIGHT  = 4'd2;
    localparam logic [3:0] OC_BOTTOM = 4'd4;
    localparam logic [3:0] OC_TOP    = 4'd8;

    localparam logic KIND_MOVE = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    typedef enum logic [1:0] {
        MDU_MUL,
        MDU_DIV
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
    } t_mdu_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_stat;

    typedef struct packed {
        logic   kind;
        t_coord x;
        t_coord y;
    } t_rec;

    typedef struct packed {
        logic   kind;
        t_coord x;
        t_coord y;
        logic   run_last;
        logic   path_done;
    } t_out_rec;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AFF_MUL,
        ST_AFF_WAIT,
        ST_AFF_SUM,
        ST_CLIP,
        ST_INT_MUL,
        ST_INT_MWAIT,
        ST_INT_DIV,
        ST_INT_DWAIT,
        ST_INT_UPD,
        ST_CLIP_END,
        ST_SNAP,
        ST_WRAP,
        ST_EMIT
    } t_state;

    function automatic logic [3:0] outcode(t_coord x, t_coord y);
        logic [3:0] c;
        c = 4'd0;
        if (x < NBOUND) c = c | OC_LEFT;
        else if (x > BOUND) c = c | OC_RIGHT;
        if (y < NBOUND) c = c | OC_BOTTOM;
        else if (y > BOUND) c = c | OC_TOP;
        return c;
    endfunction

    function automatic t_mag abs_coord(t_coord v);
        t_mag e;
        e = t_mag'(v[COORD_W-1] ? -{v[COORD_W-1], v} : {v[COORD_W-1], v});
        return e;
    endfunction

    function automatic t_mag abs_diff(logic signed [MAG_W-1:0] d);
        return d[MAG_W-1] ? t_mag'(-d) : t_mag'(d);
    endfunction

    function automatic t_coord snap_val(t_coord v, logic [1:0] mode);
        logic [COORD_W-1:0] m;
        logic [COORD_W:0]   r;
        t_coord             res;
        m   = v[COORD_W-1] ? (~v + 1'b1) : v;
        r   = {1'b0, m} + {{(COORD_W+1-FRAC_BITS){1'b0}}, FRAC_HALF};
        r[FRAC_BITS-1:0] = '0;
        res = v;
        case (mode)
            SNAP_FLOOR: res = {v[COORD_W-1:FRAC_BITS], FRAC_HALF};
            SNAP_ROUND: begin
                if (v[COORD_W-1]) begin
                    res = ~r[COORD_W-1:0] + 1'b1;
                end else if (r > {1'b0, CMAX}) begin
                    res = {CMAX[COORD_W-1:FRAC_BITS], {FRAC_BITS{1'b0}}};
                end else begin
                    res = r[COORD_W-1:0];
                end
            end
            default: res = v;
        endcase
        return res;
    endfunction

endpackage

// ===== hw/rtl/pcs_pt_if.sv =====
interface pcs_pt_if;
    import pcs_pkg::*;
    logic   valid;
    logic   ready;
    t_coord point_x;
    t_coord point_y;
    logic   point_finite;
    logic   last_vertex;

    modport source (output valid, point_x, point_y, point_finite, last_vertex, input ready);
    modport sink   (input valid, point_x, point_y, point_finite, last_vertex, output ready);
endinterface

// ===== hw/rtl/pcs_rec_if.sv =====
interface pcs_rec_if;
    import pcs_pkg::*;
    logic   valid;
    logic   ready;
    logic   record_kind;
    t_coord record_x;
    t_coord record_y;
    logic   run_last;
    logic   path_done;

    modport source (output valid, record_kind, record_x, record_y, run_last, path_done,
                    input ready);
    modport sink   (input valid, record_kind, record_x, record_y, run_last, path_done,
                    output ready);
endinterface

// ===== hw/rtl/pcs_mdu.sv =====
// Shared radix-2 unit: unsigned multiply (MAG_W steps) or restoring divide (PROD_W steps).
module pcs_mdu (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  pcs_pkg::t_mdu_req               i_req,
    input  logic [pcs_pkg::MAG_W-1:0]       i_a,
    input  logic [pcs_pkg::MAG_W-1:0]       i_b,
    input  logic [pcs_pkg::PROD_W-1:0]      i_n,
    output pcs_pkg::t_mdu_stat              o_stat,
    output logic [pcs_pkg::PROD_W-1:0]      o_res
);
    import pcs_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done;
    t_mdu_op           r_op, n_op;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [MAG_W-1:0]  r_a, n_a;
    logic [MAG_W-1:0]  r_rem, n_rem;
    logic [PROD_W-1:0] r_lo, n_lo;
    logic [PROD_W-1:0] r_acc, n_acc;
    logic [MAG_W:0]    s_sh;
    logic [MAG_W:0]    s_diff;

    assign s_sh   = {r_rem, r_lo[PROD_W-1]};
    assign s_diff = s_sh - {1'b0, r_a};

    always_comb begin
        n_busy = r_busy;
        n_op   = r_op;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_rem  = r_rem;
        n_lo   = r_lo;
        n_acc  = r_acc;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_op   = i_req.op;
            n_rem  = '0;
            n_acc  = '0;
            if (i_req.op == MDU_DIV) begin
                n_a   = i_b;
                n_lo  = i_n;
                n_cnt = CNT_W'(PROD_W);
            end else begin
                n_a   = i_a;
                n_lo  = {{(PROD_W-MAG_W){1'b0}}, i_b};
                n_cnt = CNT_W'(MAG_W);
            end
        end else if (r_busy) begin
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) n_busy = 1'b0;
            if (r_op == MDU_DIV) begin
                // remainder stays below the divisor, so MAG_W bits hold it
                if (!s_diff[MAG_W]) begin
                    n_rem = s_diff[MAG_W-1:0];
                    n_lo  = {r_lo[PROD_W-2:0], 1'b1};
                end else begin
                    n_rem = s_sh[MAG_W-1:0];
                    n_lo  = {r_lo[PROD_W-2:0], 1'b0};
                end
            end else begin
                n_acc = {r_acc[PROD_W-2:0], 1'b0} +
                        (r_lo[MAG_W-1] ? {{(PROD_W-MAG_W){1'b0}}, r_a} : '0);
                n_lo  = {r_lo[PROD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_op   <= MDU_MUL;
        end else begin
            r_busy <= n_busy;
            // result is final the cycle after the last step
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            r_cnt  <= n_cnt;
            r_op   <= n_op;
        end
        r_a   <= n_a;
        r_rem <= n_rem;
        r_lo  <= n_lo;
        r_acc <= n_acc;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_res       = (r_op == MDU_DIV) ? r_lo : r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("mdu started while busy");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("mdu busy with empty count");
    a_done_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.done |-> !r_busy) else $error("mdu still busy after done");
endmodule

// ===== hw/rtl/pcs_outreg.sv =====
// Output register: holds one record until the sink takes it.
module pcs_outreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  pcs_pkg::t_out_rec   i_rec,
    output logic                o_free,
    pcs_rec_if.source           o_rec
);
    import pcs_pkg::*;

    logic     r_valid;
    t_out_rec r_rec;

    assign o_free = !r_valid || o_rec.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rec.ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) r_rec <= i_rec;
    end

    assign o_rec.valid       = r_valid;
    assign o_rec.record_kind = r_rec.kind;
    assign o_rec.record_x    = r_rec.x;
    assign o_rec.record_y    = r_rec.y;
    assign o_rec.run_last    = r_rec.run_last;
    assign o_rec.path_done   = r_rec.path_done;
endmodule

// ===== hw/rtl/polyline_clip_and_snap_unit.sv =====
// Channel   Dir  Payload                                         Transfer
// i_pt      in   point_x, point_y, point_finite, last_vertex     valid && ready
// o_rec     out  record_kind, record_x, record_y, run_last,      valid && ready
//                path_done
// i_cfg_*   in   register index, write data                      i_cfg_we
//
// One vertex at a time; ready is high only between vertices.
// Transform: 4 multiplies (start, 49 steps, done) plus 2 sum steps.
// Each clip pass: multiply (49 steps), divide (98 steps) and control states, up to 8 passes.
// Emit: one record per cycle (up to 3) while o_rec does not stall.
// Synchronous active-low reset clears control state and config (datapath registers are not reset); no clearing pass.
module polyline_clip_and_snap_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    pcs_pt_if.sink                             i_pt,
    pcs_rec_if.source                          o_rec,
    input  logic                               i_cfg_we,
    input  logic [pcs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pcs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import pcs_pkg::*;

    t_state r_state, n_state;

    t_coef      r_mxx, r_myx, r_mxy, r_myy;
    t_coord     r_offx, r_offy;
    logic [1:0] r_snap;

    logic   r_prev_valid;
    t_coord r_prev_x, r_prev_y;
    logic   r_held_valid;
    t_rec   r_held;

    t_coord r_px, r_py;
    logic   r_fin, r_last;
    t_rec   r_rec [REC_DEPTH];
    logic [REC_CNT_W-1:0] r_n;
    logic [REC_CNT_W-1:0] r_emit;
    logic [REC_CNT_W-1:0] r_k;

    logic [1:0]               r_ph;
    logic                     r_psgn;
    logic signed [ACC_W-1:0]  r_acc;
    t_coord                   r_tx, r_ty;

    t_coord            r_x0, r_y0, r_x1, r_y1;
    logic              r_moved, r_accept;
    logic [PASS_W-1:0] r_pass;
    t_coord            r_ia0, r_it;
    t_mag              r_ma, r_mt, r_mb;
    logic              r_isgn, r_fixy, r_end0;

    logic      s_ready, s_load, s_free;
    t_mdu_req  s_req;
    t_mdu_stat s_stat;
    t_mag      s_a, s_b;
    logic [PROD_W-1:0] s_res;
    t_out_rec  s_orec;

    logic [3:0] s_c0, s_c1, s_c;
    t_coef      s_coef;
    t_coord     s_pv;
    logic signed [ACC_W-1:0] s_prod, s_sum, s_sh;
    t_coord     s_sat;
    logic       s_snap_on;
    logic       s_axis;
    t_coord     s_a0, s_a1, s_b0, s_b1, s_t;
    logic signed [MAG_W-1:0] s_da, s_dt, s_db;
    logic [MAG_W-1:0] s_q, s_iv;
    t_coord     s_v;

    pcs_mdu u_mdu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (s_req),
        .i_a    (s_a),
        .i_b    (s_b),
        .i_n    (s_res),
        .o_stat (s_stat),
        .o_res  (s_res)
    );

    pcs_outreg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (s_load),
        .i_rec  (s_orec),
        .o_free (s_free),
        .o_rec  (o_rec)
    );

    // ---------------- datapath helpers ----------------
    always_comb begin
        case (r_ph)
            2'd0:    begin s_coef = r_mxx; s_pv = r_px; end
            2'd1:    begin s_coef = r_mxy; s_pv = r_py; end
            2'd2:    begin s_coef = r_myx; s_pv = r_px; end
            default: begin s_coef = r_myy; s_pv = r_py; end
        endcase
    end

    always_comb begin
        if (r_state == ST_INT_MUL) begin
            s_a = r_ma;
            s_b = r_mt;
        end else if (r_state == ST_INT_DIV) begin
            s_a = r_ma;
            s_b = r_mb;
        end else begin
            s_a = abs_coord(t_coord'(s_coef));
            s_b = abs_coord(s_pv);
        end
    end

    assign s_prod = r_psgn ? -$signed(s_res[ACC_W-1:0]) : $signed(s_res[ACC_W-1:0]);

    // round half up, then saturate to coordinate width
    assign s_sum = r_acc + ($signed(ACC_W'(r_ph[1] ? r_offy : r_offx)) <<< MAT_FRAC)
                 + $signed(ACC_W'(1) << (MAT_FRAC - 1));
    assign s_sh  = s_sum >>> MAT_FRAC;
    always_comb begin
        if (s_sh > $signed(ACC_W'(CMAX))) s_sat = CMAX;
        else if (s_sh < $signed(ACC_W'(CMIN))) s_sat = CMIN;
        else s_sat = s_sh[COORD_W-1:0];
    end

    assign s_c0 = outcode(r_x0, r_y0);
    assign s_c1 = outcode(r_x1, r_y1);
    assign s_c  = (s_c0 != 4'd0) ? s_c0 : s_c1;

    always_comb begin
        if ((s_c & (OC_TOP | OC_BOTTOM)) != 4'd0) begin
            s_a0 = r_x0; s_a1 = r_x1; s_b0 = r_y0; s_b1 = r_y1;
            s_t  = ((s_c & OC_TOP) != 4'd0) ? BOUND : NBOUND;
        end else begin
            s_a0 = r_y0; s_a1 = r_y1; s_b0 = r_x0; s_b1 = r_x1;
            s_t  = ((s_c & OC_RIGHT) != 4'd0) ? BOUND : NBOUND;
        end
    end
    assign s_da = {s_a1[COORD_W-1], s_a1} - {s_a0[COORD_W-1], s_a0};
    assign s_dt = {s_t[COORD_W-1], s_t}   - {s_b0[COORD_W-1], s_b0};
    assign s_db = {s_b1[COORD_W-1], s_b1} - {s_b0[COORD_W-1], s_b0};

    assign s_q  = (r_mb == '0) ? '0 : s_res[MAG_W-1:0];
    assign s_iv = r_isgn ? ({r_ia0[COORD_W-1], r_ia0} - s_q) : ({r_ia0[COORD_W-1], r_ia0} + s_q);
    assign s_v  = s_iv[COORD_W-1:0];

    assign s_snap_on = (r_snap == SNAP_FLOOR) || (r_snap == SNAP_ROUND);
    assign s_axis    = (r_x1 == r_x0) || (r_y1 == r_y0);

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:
                if (i_pt.valid) n_state = i_pt.point_finite ? ST_AFF_MUL : ST_WRAP;
            ST_AFF_MUL:  n_state = ST_AFF_WAIT;
            ST_AFF_WAIT:
                if (s_stat.done) n_state = r_ph[0] ? ST_AFF_SUM : ST_AFF_MUL;
            ST_AFF_SUM: begin
                if (!r_ph[1]) n_state = ST_AFF_MUL;
                else n_state = r_prev_valid ? ST_CLIP : ST_WRAP;
            end
            ST_CLIP: begin
                if (r_pass == PASS_W'(PASS_LIMIT) || (s_c0 | s_c1) == 4'd0 ||
                    (s_c0 & s_c1) != 4'd0)
                    n_state = ST_CLIP_END;
                else
                    n_state = ST_INT_MUL;
            end
            ST_INT_MUL:   n_state = (r_mb == '0) ? ST_INT_UPD : ST_INT_MWAIT;
            ST_INT_MWAIT: if (s_stat.done) n_state = ST_INT_DIV;
            ST_INT_DIV:   n_state = ST_INT_DWAIT;
            ST_INT_DWAIT: if (s_stat.done) n_state = ST_INT_UPD;
            ST_INT_UPD:   n_state = ST_CLIP;
            ST_CLIP_END:  n_state = ST_SNAP;
            ST_SNAP:      n_state = ST_WRAP;
            ST_WRAP:      n_state = ST_EMIT;
            ST_EMIT:      if (r_k == r_emit) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    // ---------------- outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        s_load    = 1'b0;
        s_req     = '{start: 1'b0, op: MDU_MUL};
        case (r_state)
            ST_IDLE:    s_ready = 1'b1;
            ST_AFF_MUL: s_req = '{start: 1'b1, op: MDU_MUL};
            ST_INT_MUL: s_req = '{start: (r_mb != '0), op: MDU_MUL};
            ST_INT_DIV: s_req = '{start: 1'b1, op: MDU_DIV};
            ST_EMIT:    s_load = (r_k != r_emit) && s_free;
            default:    s_ready = 1'b0;
        endcase
    end

    always_comb begin
        s_orec.kind      = r_rec[r_k[REC_IDX_W-1:0]].kind;
        s_orec.x         = r_rec[r_k[REC_IDX_W-1:0]].x;
        s_orec.y         = r_rec[r_k[REC_IDX_W-1:0]].y;
        s_orec.run_last  = (r_k == r_emit - 1'b1);
        s_orec.path_done = (r_k == r_emit - 1'b1) && r_last;
    end

    assign i_pt.ready = s_ready;

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mxx  <= t_coef'(65536);
            r_myx  <= '0;
            r_mxy  <= '0;
            r_myy  <= t_coef'(65536);
            r_offx <= '0;
            r_offy <= '0;
            r_snap <= SNAP_NONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MATRIX_XX: r_mxx  <= i_cfg_data[COEF_W-1:0];
                CFG_MATRIX_YX: r_myx  <= i_cfg_data[COEF_W-1:0];
                CFG_MATRIX_XY: r_mxy  <= i_cfg_data[COEF_W-1:0];
                CFG_MATRIX_YY: r_myy  <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_X:  r_offx <= i_cfg_data[COORD_W-1:0];
                CFG_OFFSET_Y:  r_offy <= i_cfg_data[COORD_W-1:0];
                CFG_SNAP_MODE: r_snap <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_valid <= 1'b0;
            r_prev_x     <= '0;
            r_prev_y     <= '0;
            r_held_valid <= 1'b0;
            r_held       <= '0;
            r_n          <= '0;
            r_emit       <= '0;
            r_k          <= '0;
            r_ph         <= '0;
            r_pass       <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (i_pt.valid) begin
                    r_px   <= i_pt.point_x;
                    r_py   <= i_pt.point_y;
                    r_fin  <= i_pt.point_finite;
                    r_last <= i_pt.last_vertex;
                    r_rec[0] <= r_held;
                    r_n    <= REC_CNT_W'(r_held_valid);
                    r_acc  <= '0;
                    r_ph   <= '0;
                end
                ST_AFF_MUL:
                    r_psgn <= s_coef[COEF_W-1] ^ s_pv[COORD_W-1];
                ST_AFF_WAIT: if (s_stat.done) begin
                    r_acc <= r_acc + s_prod;
                    if (!r_ph[0]) r_ph <= r_ph + 1'b1;
                end
                ST_AFF_SUM: begin
                    r_acc <= '0;
                    r_ph  <= r_ph + 1'b1;
                    if (!r_ph[1]) begin
                        r_tx <= s_sat;
                    end else begin
                        r_ty     <= s_sat;
                        r_x0     <= r_prev_x;
                        r_y0     <= r_prev_y;
                        r_x1     <= r_tx;
                        r_y1     <= s_sat;
                        r_pass   <= '0;
                        r_moved  <= 1'b0;
                        if (!r_prev_valid) begin
                            r_rec[r_n[REC_IDX_W-1:0]] <= '{kind: KIND_MOVE, x: r_tx, y: s_sat};
                            r_n <= r_n + 1'b1;
                        end
                    end
                end
                ST_CLIP: begin
                    r_accept <= (r_pass != PASS_W'(PASS_LIMIT)) && ((s_c0 | s_c1) == 4'd0);
                    r_ia0    <= s_a0;
                    r_it     <= s_t;
                    r_fixy   <= (s_c & (OC_TOP | OC_BOTTOM)) != 4'd0;
                    r_end0   <= (s_c0 != 4'd0);
                    r_ma     <= abs_diff(s_da);
                    r_mt     <= abs_diff(s_dt);
                    r_mb     <= abs_diff(s_db);
                    r_isgn   <= s_da[MAG_W-1] ^ s_dt[MAG_W-1] ^ s_db[MAG_W-1];
                end
                ST_INT_UPD: begin
                    r_pass <= r_pass + 1'b1;
                    if (r_end0) begin
                        r_moved <= 1'b1;
                        r_x0 <= r_fixy ? s_v : r_it;
                        r_y0 <= r_fixy ? r_it : s_v;
                    end else begin
                        r_x1 <= r_fixy ? s_v : r_it;
                        r_y1 <= r_fixy ? r_it : s_v;
                    end
                end
                ST_CLIP_END: begin
                    if (!r_accept) begin
                        r_x0 <= r_prev_x;
                        r_y0 <= r_prev_y;
                        r_x1 <= r_tx;
                        r_y1 <= r_ty;
                    end else if (r_moved) begin
                        r_rec[r_n[REC_IDX_W-1:0]] <= '{kind: KIND_MOVE, x: r_x0, y: r_y0};
                        r_n <= r_n + 1'b1;
                    end
                end
                ST_SNAP: begin
                    // snapping rewrites the record ahead of the new endpoint
                    if (s_snap_on && s_axis) begin
                        if (r_n != '0) begin
                            r_rec[REC_IDX_W'(r_n - 1'b1)].x <= snap_val(r_x0, r_snap);
                            r_rec[REC_IDX_W'(r_n - 1'b1)].y <= snap_val(r_y0, r_snap);
                        end
                        r_rec[r_n[REC_IDX_W-1:0]] <= '{kind: r_accept,
                                                       x: snap_val(r_x1, r_snap),
                                                       y: snap_val(r_y1, r_snap)};
                    end else begin
                        r_rec[r_n[REC_IDX_W-1:0]] <= '{kind: r_accept, x: r_x1, y: r_y1};
                    end
                    r_n <= r_n + 1'b1;
                end
                ST_WRAP: begin
                    r_k <= '0;
                    if (r_last) begin
                        r_emit       <= r_n;
                        r_held_valid <= 1'b0;
                        r_held       <= '0;
                        r_prev_valid <= 1'b0;
                        r_prev_x     <= '0;
                        r_prev_y     <= '0;
                    end else begin
                        r_prev_valid <= r_fin;
                        if (r_fin) begin
                            r_prev_x <= r_tx;
                            r_prev_y <= r_ty;
                        end
                        if (r_n != '0) begin
                            r_emit       <= r_n - 1'b1;
                            r_held_valid <= 1'b1;
                            r_held       <= r_rec[REC_IDX_W'(r_n - 1'b1)];
                        end else begin
                            r_emit <= '0;
                        end
                    end
                end
                ST_EMIT: if (s_load) r_k <= r_k + 1'b1;
                default: ;
            endcase
        end
    end

    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_k <= r_emit)) else $error("emit index past count");
    a_pass_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pass <= PASS_W'(PASS_LIMIT)) else $error("clip pass count overrun");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pt.valid && i_pt.ready) |=> (r_state != ST_IDLE)) else $error("vertex dropped");
    a_rec_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= REC_CNT_W'(REC_DEPTH)) else $error("record buffer overrun");
endmodule
